/* rtl/iam_pkg.sv */
// ---------------------------------------------------------------------------
// Input action mapper package
// Shared constants, command and source codes for the action mapper.
// ---------------------------------------------------------------------------
package iam_pkg;

  localparam int MAX_BINDINGS_DEF = 32;
  localparam int NUM_ACTIONS_DEF  = 16;

  localparam int BIND_W  = 38;
  localparam int FRAME_W = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 3;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_CLEAR   = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_EVENT   = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_t;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_AXIS   = 2'd2;
  localparam logic [1:0] KIND_HAT    = 2'd3;

  localparam logic [CFG_IW-1:0] REG_DELAY    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_INTERVAL = 3'd1;
  localparam logic [CFG_IW-1:0] REG_KBD_EN   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_JOY_EN   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_JOY_SEL  = 3'd4;

endpackage

/* rtl/input_action_mapper_autorepeat.sv */
// ---------------------------------------------------------------------------
// Input action mapper with auto-repeat
// Binding table and press frames in RAM, walked one binding per cycle.
// ---------------------------------------------------------------------------
// Add, clear, release-all, unknown commands, disabled events and queries
// answered from the pressed flag alone go from acceptance straight to the
// final state, which loads the output register. An event walks the binding
// table one entry per cycle through the table RAM and then loads its result.
// A query of a pressed action under auto-repeat reads the press frame RAM
// and runs the one-bit-per-cycle remainder unit when a remainder is needed.
// A result waits in the final state while the previous one still sits
// unaccepted in the output register, and a new transaction is taken from
// the cycle after the result is loaded.
module input_action_mapper_autorepeat #(
  parameter int MAX_BINDINGS = iam_pkg::MAX_BINDINGS_DEF,
  parameter int NUM_ACTIONS  = iam_pkg::NUM_ACTIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic [1:0]         source_kind,
  input  logic               went_down,
  input  logic [15:0]        source_code,
  input  logic [7:0]         device_number,
  input  logic signed [15:0] level_value,
  input  logic [3:0]         action_id,
  input  logic [31:0]        frame_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               fires_now,
  output logic [15:0]        pressed_mask,
  output logic               status,
  input  logic               cfg_we,
  input  logic [iam_pkg::CFG_IW-1:0] cfg_index,
  input  logic [iam_pkg::CFG_W-1:0]  cfg_data
);

  localparam int IW = MAX_BINDINGS > 1 ? $clog2(MAX_BINDINGS) : 1;
  localparam int CW = $clog2(MAX_BINDINGS + 1);
  localparam int AW = NUM_ACTIONS > 1 ? $clog2(NUM_ACTIONS) : 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WALK  = 7'b0000010,
    ST_QRD   = 7'b0000100,
    ST_QWAIT = 7'b0001000,
    ST_QTEST = 7'b0010000,
    ST_QDIV  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t state;

  logic [15:0] repeat_delay;
  logic [15:0] repeat_interval;
  logic        keyboard_enable;
  logic        joystick_enable;
  logic [7:0]  joystick_select;

  logic [1:0]         kind_q;
  logic               down_q;
  logic [15:0]        code_q;
  logic signed [15:0] level_q;
  logic [AW-1:0]      act_q;
  logic [31:0]        frame_q;

  logic [CW-1:0]          bind_count;
  logic [CW-1:0]          walk_cnt;
  logic                   ev_valid;
  logic [NUM_ACTIONS-1:0] pressed;
  logic [31:0]            elapsed;
  logic                   fires_r;
  logic                   status_r;

  logic                       accept;
  logic                       bind_we;
  logic [IW-1:0]              bind_raddr;
  logic [iam_pkg::BIND_W-1:0] bind_rdata;
  logic [31:0]                pf_rdata;
  logic                       pf_we;

  logic                mod_start;
  logic                mod_done;
  logic [15:0]         mod_rem;
  logic [15:0]         iv;

  logic [1:0]         b_kind;
  logic [15:0]        b_code;
  logic signed [15:0] b_level;
  logic [3:0]         b_act;
  logic [AW-1:0]      b_idx;
  logic               b_match;
  logic               p_cur;
  logic               do_press;
  logic               p_new;
  logic [15:0]        hat_and;

  logic          act_in_range;
  logic [AW-1:0] act_idx;
  logic          ev_enabled;
  logic [15:0]   mask16;

  assign accept       = in_valid && in_ready;
  assign in_ready     = (state == ST_IDLE);
  assign act_in_range = {3'b000, action_id} < 7'(NUM_ACTIONS);
  assign act_idx      = AW'(action_id);
  assign iv           = (repeat_interval == 16'd0) ? 16'd1 : repeat_interval;
  assign ev_enabled   = (source_kind == iam_pkg::KIND_KEY) ? keyboard_enable :
                        (joystick_enable && device_number == joystick_select);
  assign bind_we      = accept && command == iam_pkg::CMD_ADD &&
                        bind_count < CW'(MAX_BINDINGS);
  assign bind_raddr   = walk_cnt[IW-1:0];

  assign b_kind  = bind_rdata[37:36];
  assign b_code  = bind_rdata[35:20];
  assign b_level = bind_rdata[19:4];
  assign b_act   = bind_rdata[3:0];
  assign b_idx   = AW'(b_act);
  assign b_match = ev_valid && b_kind == kind_q && b_code == code_q &&
                   ({3'b000, b_act} < 7'(NUM_ACTIONS));
  assign p_cur   = pressed[b_idx];
  assign hat_and = level_q & b_level;

  always_comb begin
    do_press = 1'b0;
    p_new    = p_cur;
    case (kind_q)
      iam_pkg::KIND_KEY, iam_pkg::KIND_BUTTON: begin
        do_press = down_q && !p_cur;
        p_new    = down_q;
      end
      iam_pkg::KIND_AXIS: begin
        if (!p_cur) begin
          do_press = (b_level < 0) ? (b_level > level_q) : (b_level < level_q);
          p_new    = do_press;
        end else begin
          p_new = !((b_level < 0) ? (b_level < level_q) : (b_level > level_q));
        end
      end
      default: begin
        do_press = (hat_and == b_level) && !p_cur;
        p_new    = (do_press || p_cur) && (hat_and != 16'd0);
      end
    endcase
  end

  assign pf_we = b_match && do_press;

  genvar g;
  generate
    for (g = 0; g < 16; g++) begin : g_mask
      if (g < NUM_ACTIONS) begin : g_on
        assign mask16[g] = pressed[g];
      end else begin : g_off
        assign mask16[g] = 1'b0;
      end
    end
  endgenerate

  iam_ram #(.WIDTH(iam_pkg::BIND_W), .DEPTH(MAX_BINDINGS)) u_bind_ram (
    .clk   (clk),
    .we    (bind_we),
    .waddr (bind_count[IW-1:0]),
    .wdata ({source_kind, source_code, level_value, action_id}),
    .raddr (bind_raddr),
    .rdata (bind_rdata)
  );

  iam_ram #(.WIDTH(iam_pkg::FRAME_W), .DEPTH(NUM_ACTIONS)) u_frame_ram (
    .clk   (clk),
    .we    (pf_we),
    .waddr (b_idx),
    .wdata (frame_q),
    .raddr (act_q),
    .rdata (pf_rdata)
  );

  assign mod_start = (state == ST_QTEST) && elapsed != 32'd0 &&
                     elapsed >= {16'd0, repeat_delay};

  iam_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (elapsed - {16'd0, repeat_delay}),
    .divisor   (iv),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay    <= '0;
      repeat_interval <= 16'd1;
      keyboard_enable <= 1'b1;
      joystick_enable <= 1'b0;
      joystick_select <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        iam_pkg::REG_DELAY:    repeat_delay    <= cfg_data;
        iam_pkg::REG_INTERVAL: repeat_interval <= cfg_data;
        iam_pkg::REG_KBD_EN:   keyboard_enable <= cfg_data[0];
        iam_pkg::REG_JOY_EN:   joystick_enable <= cfg_data[0];
        iam_pkg::REG_JOY_SEL:  joystick_select <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= source_kind;
      down_q  <= went_down;
      code_q  <= source_code;
      level_q <= level_value;
      act_q   <= act_idx;
      frame_q <= frame_number;
    end
    if (state == ST_QWAIT) begin
      elapsed <= frame_q - pf_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bind_count <= '0;
      walk_cnt   <= '0;
      ev_valid   <= 1'b0;
      pressed    <= '0;
      fires_r    <= 1'b0;
      status_r   <= 1'b0;
      out_valid  <= 1'b0;
      fires_now  <= 1'b0;
      status     <= 1'b0;
      pressed_mask <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (b_match) begin
        pressed[b_idx] <= p_new;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fires_r  <= 1'b0;
            status_r <= 1'b0;
            walk_cnt <= '0;
            ev_valid <= 1'b0;
            state    <= ST_FIN;
            case (command)
              iam_pkg::CMD_ADD: begin
                if (bind_count < CW'(MAX_BINDINGS)) begin
                  bind_count <= bind_count + CW'(1);
                end else begin
                  status_r <= 1'b1;
                end
              end
              iam_pkg::CMD_CLEAR:   bind_count <= '0;
              iam_pkg::CMD_RELEASE: pressed <= '0;
              iam_pkg::CMD_EVENT: begin
                if (ev_enabled) begin
                  state <= ST_WALK;
                end
              end
              iam_pkg::CMD_QUERY: begin
                if (act_in_range) begin
                  if (repeat_delay == 16'd0) begin
                    fires_r <= pressed[act_idx];
                  end else if (pressed[act_idx]) begin
                    state <= ST_QRD;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (walk_cnt < bind_count) begin
            walk_cnt <= walk_cnt + CW'(1);
            ev_valid <= 1'b1;
          end else begin
            ev_valid <= 1'b0;
            if (!ev_valid) begin
              state <= ST_FIN;
            end
          end
        end
        ST_QRD:   state <= ST_QWAIT;
        ST_QWAIT: state <= ST_QTEST;
        ST_QTEST: begin
          if (elapsed == 32'd0) begin
            fires_r <= 1'b1;
            state   <= ST_FIN;
          end else if (elapsed < {16'd0, repeat_delay}) begin
            state <= ST_FIN;
          end else begin
            state <= ST_QDIV;
          end
        end
        ST_QDIV: begin
          if (mod_done) begin
            fires_r <= (mod_rem == 16'd0);
            state   <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            fires_now    <= fires_r;
            status       <= status_r;
            pressed_mask <= mask16;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bind_count <= CW'(MAX_BINDINGS))
    else $error("binding count above table depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> walk_cnt <= bind_count)
    else $error("table walk past last binding");

  a_mod_owner: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == ST_QDIV)
    else $error("remainder result outside query");

endmodule

/* rtl/iam_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module iam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/iam_mod.sv */
// ---------------------------------------------------------------------------
// Remainder unit
// Restoring remainder of a 32-bit value by a 16-bit divisor, one bit a cycle.
// ---------------------------------------------------------------------------
module iam_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);

  logic [31:0] dvd;
  logic [15:0] dvs;
  logic [16:0] rem;
  logic [5:0]  steps;
  logic        busy;
  logic [16:0] trial;
  logic [16:0] rem_next;

  always_comb begin
    trial    = {rem[15:0], dvd[31]};
    rem_next = (trial >= {1'b0, dvs}) ? trial - {1'b0, dvs} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 6'd1;
        if (steps == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem[15:0];

endmodule
